>>> sv/pbe_pkg.sv
// Shared types, constants and elaboration-time helpers for the Phong BRDF block.
// No dependencies; imported by every module of the block.
`default_nettype none
package pbe_pkg;

  localparam int VECTOR_FRAC_BITS = 14;
  localparam int RESULT_FRAC_BITS = 16;

  localparam int IN_W  = 144;   // nine 16-bit vector components
  localparam int OUT_W = 96;    // four 24-bit results

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;   // round(2^32/pi)
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [16:0] KS_ONE     = 17'd65536;
  localparam logic [15:0] SHIN_MIN   = 16'd256;
  localparam logic [23:0] OUT_MAX    = 24'hFF_FFFF;

  localparam logic [15:0] ALBEDO_RST = 16'd52429;
  localparam logic [16:0] KS_RST     = 17'd19661;
  localparam logic [15:0] SHIN_RST   = 16'd8192;

  typedef enum logic [2:0] {
    CFG_ALBEDO_RED   = 3'd0,
    CFG_ALBEDO_GREEN = 3'd1,
    CFG_ALBEDO_BLUE  = 3'd2,
    CFG_SPEC_WEIGHT  = 3'd3,
    CFG_SHININESS    = 3'd4
  } cfg_idx_t;

  // classified item handed from the front end to the back end
  typedef struct packed {
    logic              zero;     // light below surface
    logic [32:0]       ct;       // wi.n, signed
    logic [32:0]       dwn;      // wo.n, signed
    logic [2:0][15:0]  nv;
    logic [2:0][15:0]  wo;
    logic [2:0][15:0]  wi;
  } fitem_t;

  // diffuse sideband carried alongside the specular pipeline
  typedef struct packed {
    logic        zero;
    logic [34:0] d32;
  } side_t;

  // clamped configuration seen by the datapath
  typedef struct packed {
    logic [16:0] ks;
    logic [16:0] kd;
    logic [15:0] n;
  } cfg_t;

  function automatic logic [63:0] isqrt_f(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = x;
    res = '0;
    bt  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bt) begin
        v   = v - res - bt;
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Q30 factor 2^(-2^-k), built by repeated square roots
  function automatic logic [29:0] exp_coef(input int k);
    logic [63:0] c;
    c = isqrt_f(64'd1 << 59);
    for (int j = 1; j < k; j++) begin
      c = isqrt_f(c << 30);
    end
    return c[29:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/pbe_front.sv
// Front end: input register that takes items and works out wi.n and wo.n.
// Depends on pbe_pkg.
`default_nettype none
module pbe_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pbe_pkg::IN_W-1:0]   in_data,
  input  logic                       q_full,
  output logic                       push,
  output pbe_pkg::fitem_t            push_item
);
  import pbe_pkg::*;

  logic            f_valid_r;
  fitem_t          f_item_r;
  fitem_t          f_item_nxt;
  logic signed [15:0] nv [3];
  logic signed [15:0] wo [3];
  logic signed [15:0] wi [3];
  logic signed [31:0] pc [3];
  logic signed [31:0] pd [3];
  logic signed [32:0] ct;
  logic signed [32:0] dwn;

  assign in_ready = !f_valid_r || !q_full;
  assign push     = f_valid_r && !q_full;
  assign push_item = f_item_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i] = $signed(in_data[16*i +: 16]);
      wo[i] = $signed(in_data[48 + 16*i +: 16]);
      wi[i] = $signed(in_data[96 + 16*i +: 16]);
      pc[i] = wi[i] * nv[i];
      pd[i] = wo[i] * nv[i];
    end
    ct  = 33'(pc[0]) + 33'(pc[1]) + 33'(pc[2]);
    dwn = 33'(pd[0]) + 33'(pd[1]) + 33'(pd[2]);
    f_item_nxt.zero = (ct <= 33'sd0);
    f_item_nxt.ct   = ct;
    f_item_nxt.dwn  = dwn;
    for (int i = 0; i < 3; i++) begin
      f_item_nxt.nv[i] = nv[i];
      f_item_nxt.wo[i] = wo[i];
      f_item_nxt.wi[i] = wi[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ready) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_item_r <= f_item_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/pbe_queue.sv
// Short FIFO of classified items between the front and back ends.
// Depends on pbe_pkg.
`default_nettype none
module pbe_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pbe_pkg::fitem_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output pbe_pkg::fitem_t  head_item
);
  import pbe_pkg::*;

  fitem_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic [QCNT_W-1:0]   cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (cnt_r == '0);
  assign head_item = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= push_item;
  end

  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue full but pointers differ");

  a_part_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (!full && !empty) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue partly filled but pointers equal");

endmodule
`default_nettype wire

>>> sv/pbe_cosine.sv
// Back end, first half: reflection, length, diffuse term and cosAlpha (Q30).
// Pipelined square root and divider, one bit per stage. Depends on pbe_pkg.
`default_nettype none
module pbe_cosine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  pbe_pkg::fitem_t  in_item,
  input  logic [16:0]      kd,
  output logic             out_valid,
  output logic [30:0]      out_ca,
  output pbe_pkg::side_t   out_side
);
  import pbe_pkg::*;

  localparam int SQ_N  = 32;
  localparam int DIV_N = 30;

  // C1: reflection vector, kd*cosTheta
  logic                c1_valid_r, c1_zero_r;
  logic [31:0]         c1_t_r;
  logic signed [51:0]  c1_r_r [3];
  logic [2:0][15:0]    c1_wi_r;
  logic [48:0]         t_prod;
  logic signed [33:0]  dwn2;
  logic signed [49:0]  rp [3];
  logic signed [51:0]  c1_r_nxt [3];

  // C2: magnitudes, diffuse scale
  logic                c2_valid_r;
  side_t               c2_side_r;
  logic [50:0]         c2_mag_r [3];
  logic [2:0]          c2_neg_r;
  logic [2:0][15:0]    c2_wi_r;
  logic [62:0]         d_prod;
  logic [51:0]         negr [3];

  // C3: normalising shift
  logic                c3_valid_r;
  side_t               c3_side_r;
  logic [50:0]         c3_mag_r [3];
  logic [2:0]          c3_neg_r;
  logic [2:0][15:0]    c3_wi_r;
  logic [4:0]          c3_s_r;
  logic [50:0]         mx;
  logic [5:0]          bl;
  logic [4:0]          s_nxt;

  // C4: shifted components
  logic                c4_valid_r;
  side_t               c4_side_r;
  logic [29:0]         c4_m_r [3];
  logic signed [30:0]  c4_rs_r [3];
  logic [2:0][15:0]    c4_wi_r;
  logic [50:0]         sh [3];

  // C5: squares and dot products
  logic                c5_valid_r;
  side_t               c5_side_r;
  logic [59:0]         c5_sq_r [3];
  logic signed [46:0]  c5_dp_r [3];

  // square root pipeline, entry 0 holds len2 and wi.r
  logic [SQ_N:0]       sv_r;
  logic [61:0]         sx_r [0:SQ_N];
  logic [62:0]         sr_r [0:SQ_N];
  logic signed [48:0]  sd_r [0:SQ_N];
  side_t               ss_r [0:SQ_N];

  // divider pipeline
  logic [DIV_N:0]      dv_v_r;
  logic [31:0]         dv_rem_r  [0:DIV_N];
  logic [31:0]         dv_norm_r [0:DIV_N];
  logic [DIV_N-1:0]    dv_q_r    [0:DIV_N];
  logic [DIV_N:0]      dv_ca0_r;
  logic [DIV_N:0]      dv_one_r;
  side_t               dv_side_r [0:DIV_N];
  logic [31:0]         norm;
  logic signed [48:0]  dot_end;

  always_comb begin
    t_prod = kd * in_item.ct[31:0];
    dwn2   = $signed({in_item.dwn, 1'b0});
    for (int i = 0; i < 3; i++) begin
      rp[i] = dwn2 * $signed(in_item.nv[i]);
      c1_r_nxt[i] = 52'(rp[i]) - (52'($signed(in_item.wo[i])) <<< (2 * VECTOR_FRAC_BITS));
    end
  end

  always_comb begin
    d_prod = c1_t_r * INV_PI_Q32;
    for (int i = 0; i < 3; i++) begin
      negr[i] = -c1_r_r[i];
    end
  end

  always_comb begin
    mx = c2_mag_r[0] | c2_mag_r[1] | c2_mag_r[2];
    bl = '0;
    for (int b = 0; b < 51; b++) begin
      if (mx[b]) bl = 6'(b + 1);
    end
    s_nxt = (bl > 6'd30) ? 5'(bl - 6'd30) : 5'd0;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = c3_mag_r[i] >> c3_s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_zero_r <= in_item.zero;
      c1_t_r    <= t_prod[47:16];
      c1_wi_r   <= in_item.wi;
      for (int i = 0; i < 3; i++) c1_r_r[i] <= c1_r_nxt[i];

      c2_side_r.zero <= c1_zero_r;
      c2_side_r.d32  <= d_prod[2*VECTOR_FRAC_BITS +: 35];
      c2_wi_r        <= c1_wi_r;
      for (int i = 0; i < 3; i++) begin
        c2_neg_r[i] <= c1_r_r[i][51];
        c2_mag_r[i] <= c1_r_r[i][51] ? negr[i][50:0] : c1_r_r[i][50:0];
      end

      c3_side_r <= c2_side_r;
      c3_wi_r   <= c2_wi_r;
      c3_neg_r  <= c2_neg_r;
      c3_s_r    <= s_nxt;
      for (int i = 0; i < 3; i++) c3_mag_r[i] <= c2_mag_r[i];

      c4_side_r <= c3_side_r;
      c4_wi_r   <= c3_wi_r;
      for (int i = 0; i < 3; i++) begin
        c4_m_r[i]  <= sh[i][29:0];
        c4_rs_r[i] <= c3_neg_r[i] ? -$signed({1'b0, sh[i][29:0]})
                                  : $signed({1'b0, sh[i][29:0]});
      end

      c5_side_r <= c4_side_r;
      for (int i = 0; i < 3; i++) begin
        c5_sq_r[i] <= c4_m_r[i] * c4_m_r[i];
        c5_dp_r[i] <= $signed(c4_wi_r[i]) * c4_rs_r[i];
      end

      sx_r[0] <= 62'(c5_sq_r[0]) + 62'(c5_sq_r[1]) + 62'(c5_sq_r[2]);
      sr_r[0] <= '0;
      sd_r[0] <= 49'(c5_dp_r[0]) + 49'(c5_dp_r[1]) + 49'(c5_dp_r[2]);
      ss_r[0] <= c5_side_r;
    end
  end

  // one root bit per stage
  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*j);
    logic [63:0] sum;
    logic        ge;
    assign sum = {1'b0, sr_r[j]} + BIT;
    assign ge  = {2'b0, sx_r[j]} >= sum;
    always_ff @(posedge clk) begin
      if (adv) begin
        sx_r[j+1] <= ge ? sx_r[j] - sum[61:0] : sx_r[j];
        sr_r[j+1] <= ge ? (sr_r[j] >> 1) + BIT[62:0] : (sr_r[j] >> 1);
        sd_r[j+1] <= sd_r[j];
        ss_r[j+1] <= ss_r[j];
      end
    end
  end

  assign norm    = sr_r[SQ_N][31:0];
  assign dot_end = sd_r[SQ_N];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0]  <= dot_end[31:0];
      dv_norm_r[0] <= norm;
      dv_q_r[0]    <= '0;
      dv_ca0_r[0]  <= (norm == '0) || (dot_end <= 49'sd0);
      dv_one_r[0]  <= dot_end >= $signed({17'd0, norm});
      dv_side_r[0] <= ss_r[SQ_N];
    end
  end

  // one quotient bit per stage, remainder stays below the length
  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    logic [32:0] r2;
    logic [32:0] diff;
    logic        ge;
    assign r2   = {dv_rem_r[k], 1'b0};
    assign diff = r2 - {1'b0, dv_norm_r[k]};
    assign ge   = r2 >= {1'b0, dv_norm_r[k]};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[k+1]  <= ge ? diff[31:0] : r2[31:0];
        dv_q_r[k+1]    <= {dv_q_r[k][DIV_N-2:0], ge};
        dv_norm_r[k+1] <= dv_norm_r[k];
        dv_ca0_r[k+1]  <= dv_ca0_r[k];
        dv_one_r[k+1]  <= dv_one_r[k];
        dv_side_r[k+1] <= dv_side_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_valid_r <= 1'b0;
      c2_valid_r <= 1'b0;
      c3_valid_r <= 1'b0;
      c4_valid_r <= 1'b0;
      c5_valid_r <= 1'b0;
      sv_r       <= '0;
      dv_v_r     <= '0;
    end else if (adv) begin
      c1_valid_r <= in_valid;
      c2_valid_r <= c1_valid_r;
      c3_valid_r <= c2_valid_r;
      c4_valid_r <= c3_valid_r;
      c5_valid_r <= c4_valid_r;
      sv_r       <= {sv_r[SQ_N-1:0], c5_valid_r};
      dv_v_r     <= {dv_v_r[DIV_N-1:0], sv_r[SQ_N]};
    end
  end

  assign out_valid = dv_v_r[DIV_N];
  assign out_side  = dv_side_r[DIV_N];
  assign out_ca    = dv_ca0_r[DIV_N] ? 31'd0 :
                     dv_one_r[DIV_N] ? ONE_Q30 : {1'b0, dv_q_r[DIV_N]};

  a_div_pre: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v_r[0] && !dv_ca0_r[0] && !dv_one_r[0]) |-> (dv_rem_r[0] < dv_norm_r[0]))
    else $error("divider entered with dividend not below length");

endmodule
`default_nettype wire

>>> sv/pbe_power.sv
// Back end, second half: cosAlpha^n by log2 (repeated squaring) and exp2
// (product of fixed root factors). Depends on pbe_pkg.
`default_nettype none
module pbe_power (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [30:0]      in_ca,
  input  pbe_pkg::side_t   in_side,
  input  logic [15:0]      shin,
  output logic             out_valid,
  output logic [30:0]      out_pw,
  output pbe_pkg::side_t   out_side
);
  import pbe_pkg::*;

  localparam int LOG_N = 24;
  localparam int EXP_N = 24;

  // log2 stages
  logic [LOG_N:0]  lv_r;
  logic [30:0]     lm_r  [0:LOG_N];
  logic [23:0]     lf_r  [0:LOG_N];
  logic [4:0]      lk_r  [0:LOG_N];
  logic [LOG_N:0]  lpz_r;
  logic [LOG_N:0]  lpo_r;
  side_t           ls_r  [0:LOG_N];
  logic [4:0]      p;
  logic [4:0]      k_nxt;

  // scale by n
  logic            ev_r, epz_r, epo_r;
  logic [36:0]     e_r;
  side_t           es_r;
  logic [28:0]     lg;
  logic [44:0]     e_prod;

  // exp2 stages
  logic [EXP_N:0]  xv_r;
  logic [30:0]     xres_r [0:EXP_N];
  logic [23:0]     xf_r   [0:EXP_N];
  logic [4:0]      xip_r  [0:EXP_N];
  logic [EXP_N:0]  xz_r;
  logic [EXP_N:0]  xo_r;
  side_t           xs_r   [0:EXP_N];
  logic [12:0]     ipf;

  // result
  logic            fv_r;
  logic [30:0]     pw_r;
  side_t           fs_r;

  always_comb begin
    p = '0;
    for (int b = 0; b < 30; b++) begin
      if (in_ca[b]) p = 5'(b);
    end
    k_nxt = 5'd30 - p;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lm_r[0]  <= {1'b0, in_ca[29:0]} << k_nxt;
      lf_r[0]  <= '0;
      lk_r[0]  <= k_nxt;
      lpz_r[0] <= (in_ca == '0);
      lpo_r[0] <= in_ca[30];
      ls_r[0]  <= in_side;
    end
  end

  for (genvar j = 0; j < LOG_N; j++) begin : g_log
    logic [61:0] sq;
    logic [31:0] hi;
    assign sq = lm_r[j] * lm_r[j];
    assign hi = sq[61:30];
    always_ff @(posedge clk) begin
      if (adv) begin
        lm_r[j+1]  <= hi[31] ? hi[31:1] : hi[30:0];
        lf_r[j+1]  <= {lf_r[j][22:0], hi[31]};
        lk_r[j+1]  <= lk_r[j];
        lpz_r[j+1] <= lpz_r[j];
        lpo_r[j+1] <= lpo_r[j];
        ls_r[j+1]  <= ls_r[j];
      end
    end
  end

  assign lg     = {lk_r[LOG_N], 24'd0} - {5'd0, lf_r[LOG_N]};
  assign e_prod = lg * shin;
  assign ipf    = e_r[36:24];

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r   <= e_prod[44:8];
      epz_r <= lpz_r[LOG_N];
      epo_r <= lpo_r[LOG_N];
      es_r  <= ls_r[LOG_N];

      xres_r[0] <= ONE_Q30;
      xf_r[0]   <= e_r[23:0];
      xip_r[0]  <= ipf[4:0];
      xz_r[0]   <= epz_r || ((ipf >= 13'd31) && !epo_r);
      xo_r[0]   <= epo_r;
      xs_r[0]   <= es_r;
    end
  end

  for (genvar k = 1; k <= EXP_N; k++) begin : g_exp
    localparam logic [29:0] CK = exp_coef(k);
    logic [60:0] prod;
    assign prod = xres_r[k-1] * CK;
    always_ff @(posedge clk) begin
      if (adv) begin
        xres_r[k] <= xf_r[k-1][EXP_N-k] ? prod[60:30] : xres_r[k-1];
        xf_r[k]   <= xf_r[k-1];
        xip_r[k]  <= xip_r[k-1];
        xz_r[k]   <= xz_r[k-1];
        xo_r[k]   <= xo_r[k-1];
        xs_r[k]   <= xs_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pw_r <= xz_r[EXP_N] ? 31'd0 :
              xo_r[EXP_N] ? ONE_Q30 : (xres_r[EXP_N] >> xip_r[EXP_N]);
      fs_r <= xs_r[EXP_N];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
      ev_r <= 1'b0;
      xv_r <= '0;
      fv_r <= 1'b0;
    end else if (adv) begin
      lv_r <= {lv_r[LOG_N-1:0], in_valid};
      ev_r <= lv_r[LOG_N];
      xv_r <= {xv_r[EXP_N-1:0], ev_r};
      fv_r <= xv_r[EXP_N];
    end
  end

  assign out_valid = fv_r;
  assign out_pw    = pw_r;
  assign out_side  = fs_r;

  a_pw_range: assert property (@(posedge clk) disable iff (!rst_n)
    xv_r[EXP_N] |-> (xres_r[EXP_N] <= ONE_Q30))
    else $error("exp2 product above one");

endmodule
`default_nettype wire

>>> sv/phong_brdf_eval.sv
// Top level of the normalised Phong BRDF evaluator: configuration registers,
// front end, item queue, back-end pipeline and output register. Depends on pbe_pkg.
//
// One shading item in, one RGB BRDF value plus sample density out, one item per
// clock sustained while the output is not stalled. The front end registers each
// item and forms wi.n and wo.n; items then sit in a four-entry queue so the input
// side keeps taking a few items while the output is stalled. The back end is a
// single pipeline of 123 stages that advances whenever the output register is
// free or being taken; an item passes the input register, the queue and then the
// back end. Its length is set by the bit-per-stage square root (32 stages)
// and divider (30 stages) for cosAlpha, and by the 24 log2 squaring and 24 exp2
// stages of the power term. The specular scale ks*(n+1)/(2pi) is rebuilt from
// the configuration registers through a_prod_r, a_hi_r/a_lo_r and a_r after a
// write, well before an item that follows the write reaches the final combine,
// so an item may follow a write immediately. Light below the surface gives four
// zero results. Results are unsigned Q8.16 and saturate.
`default_nettype none
module phong_brdf_eval (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata, from bit 0: normal_x, normal_y, normal_z, outgoing_x,
  // outgoing_y, outgoing_z, incoming_x, incoming_y, incoming_z (16 bits each)
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [pbe_pkg::IN_W-1:0]   in_tdata,
  // out_tdata, from bit 0: brdf_red, brdf_green, brdf_blue, sample_density
  // (24 bits each)
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [pbe_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [16:0]                cfg_data
);
  import pbe_pkg::*;

  // configuration registers
  logic [15:0] alb_red_r, alb_grn_r, alb_blu_r;
  logic [16:0] ks_reg_r;
  logic [15:0] shin_r;
  cfg_t        cfg;

  // specular scale, rebuilt through a_prod_r, a_hi_r/a_lo_r and a_r after a write
  logic [33:0] a_prod_r;
  logic [47:0] a_hi_r, a_lo_r;
  logic [29:0] a_r;
  logic [64:0] a_sum;

  // front end and queue
  logic        f_push, q_full, q_empty, q_pop;
  fitem_t      f_item, q_head;

  // back end
  logic        adv;
  logic        cs_valid;
  logic [30:0] cs_ca;
  side_t       cs_side;
  logic        pw_valid;
  logic [30:0] pw_val;
  side_t       pw_side;

  // final combine
  logic        f0_valid_r;
  logic        f0_zero_r;
  logic [60:0] f0_sp_r;
  logic [50:0] f0_dr_r, f0_dg_r, f0_db_r;
  logic [34:0] f0_d32_r;
  logic [38:0] spec;
  logic [23:0] res_red, res_grn, res_blu, res_den;

  logic                 out_valid_r;
  logic [OUT_W-1:0]     out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alb_red_r <= ALBEDO_RST;
      alb_grn_r <= ALBEDO_RST;
      alb_blu_r <= ALBEDO_RST;
      ks_reg_r  <= KS_RST;
      shin_r    <= SHIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ALBEDO_RED:   alb_red_r <= cfg_data[15:0];
        CFG_ALBEDO_GREEN: alb_grn_r <= cfg_data[15:0];
        CFG_ALBEDO_BLUE:  alb_blu_r <= cfg_data[15:0];
        CFG_SPEC_WEIGHT:  ks_reg_r  <= cfg_data;
        CFG_SHININESS:    shin_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // clamp out-of-range weights and exponents
  always_comb begin
    cfg.ks = (ks_reg_r > KS_ONE) ? KS_ONE : ks_reg_r;
    cfg.kd = KS_ONE - cfg.ks;
    cfg.n  = (shin_r < SHIN_MIN) ? SHIN_MIN : shin_r;
  end

  // a = ks*(n+1)*INV_PI/2 in Q24, product split into two halves
  assign a_sum = {a_hi_r, 17'd0} + 65'(a_lo_r);

  always_ff @(posedge clk) begin
    a_prod_r <= cfg.ks * (17'(cfg.n) + 17'(SHIN_MIN));
    a_hi_r   <= a_prod_r[33:17] * INV_PI_Q32;
    a_lo_r   <= a_prod_r[16:0] * INV_PI_Q32;
    a_r      <= a_sum[62:33];
  end

  pbe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .q_full    (q_full),
    .push      (f_push),
    .push_item (f_item)
  );

  pbe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (q_head)
  );

  // whole back end moves together whenever the output slot can take a result
  assign adv   = !out_valid_r || out_tready;
  assign q_pop = adv && !q_empty;

  pbe_cosine u_cosine (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (q_pop),
    .in_item   (q_head),
    .kd        (cfg.kd),
    .out_valid (cs_valid),
    .out_ca    (cs_ca),
    .out_side  (cs_side)
  );

  pbe_power u_power (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (cs_valid),
    .in_ca     (cs_ca),
    .in_side   (cs_side),
    .shin      (cfg.n),
    .out_valid (pw_valid),
    .out_pw    (pw_val),
    .out_side  (pw_side)
  );

  // F0: specular and per-colour diffuse products
  always_ff @(posedge clk) begin
    if (adv) begin
      f0_zero_r <= pw_side.zero;
      f0_d32_r  <= pw_side.d32;
      f0_sp_r   <= a_r * pw_val;
      f0_dr_r   <= alb_red_r * pw_side.d32;
      f0_dg_r   <= alb_grn_r * pw_side.d32;
      f0_db_r   <= alb_blu_r * pw_side.d32;
    end
  end

  function automatic logic [23:0] finish(input logic [47:0] v);
    logic [47:0] sh;
    sh = v >> (32 - RESULT_FRAC_BITS);
    return (|sh[47:24]) ? OUT_MAX : sh[23:0];
  endfunction

  assign spec    = {f0_sp_r[59:30], 8'd0} + 39'd0;
  assign res_red = finish(48'(f0_dr_r[50:16]) + 48'(spec));
  assign res_grn = finish(48'(f0_dg_r[50:16]) + 48'(spec));
  assign res_blu = finish(48'(f0_db_r[50:16]) + 48'(spec));
  assign res_den = finish(48'(f0_d32_r) + 48'(spec));

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= f0_zero_r ? '0 : {res_den, res_blu, res_grn, res_red};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      f0_valid_r  <= pw_valid;
      out_valid_r <= f0_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // albedo is below one, so no colour can exceed the density
  a_den_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r[95:72] >= out_data_r[23:0]) &&
                     (out_data_r[95:72] >= out_data_r[47:24]) &&
                     (out_data_r[95:72] >= out_data_r[71:48])))
    else $error("colour result above sample density");

endmodule
`default_nettype wire

>>> dv/tb_phong_brdf_eval.sv
// Self-checking testbench for phong_brdf_eval: random and directed shading items,
// predicted results compared field by field in a small scoreboard class.
// Depends on pbe_pkg and the phong_brdf_eval RTL.
`default_nettype none
module tb_phong_brdf_eval;
  timeunit 1ns;
  timeprecision 1ps;
  import pbe_pkg::*;

  localparam longint unsigned INV_PI = 64'd1367130551;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  // result of one shading item
  typedef struct packed {
    logic [23:0] density;
    logic [23:0] blue;
    logic [23:0] green;
    logic [23:0] red;
  } brdf_res_t;

  // ---------------------------------------------------------------------
  // Predictor: shading maths in 64-bit arithmetic, truncating throughout.
  // ---------------------------------------------------------------------
  class brdf_scoreboard;
    logic [15:0] alb_r, alb_g, alb_b, shin;
    logic [16:0] ks_reg;
    brdf_res_t   pending[$];
    int          mismatches;

    function new();
      alb_r = ALBEDO_RST; alb_g = ALBEDO_RST; alb_b = ALBEDO_RST;
      ks_reg = KS_RST; shin = SHIN_RST;
      mismatches = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [16:0] val);
      case (idx)
        CFG_ALBEDO_RED:   alb_r = val[15:0];
        CFG_ALBEDO_GREEN: alb_g = val[15:0];
        CFG_ALBEDO_BLUE:  alb_b = val[15:0];
        CFG_SPEC_WEIGHT:  ks_reg = val;
        CFG_SHININESS:    shin = val[15:0];
        default: ;
      endcase
    endfunction

    static function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bt;
      res = 0; bt = 64'd1 << 62;
      while (bt > x) bt >>= 2;
      while (bt != 0) begin
        if (x >= res + bt) begin
          x -= res + bt; res = (res >> 1) + bt;
        end else res >>= 1;
        bt >>= 2;
      end
      return res;
    endfunction

    // cosAlpha^n, cosAlpha Q30, n Q8.8
    static function longint unsigned cos_pow(longint unsigned ca, longint unsigned n);
      longint unsigned m, frac, lg, e, ip, f, res, c;
      int p;
      if (ca == 0) return 0;
      if (ca >= Q30_ONE) return Q30_ONE;
      p = 29;
      while (p > 0 && ca[p] == 1'b0) p--;
      m = ca << (30 - p);
      frac = 0;
      for (int k = 0; k < 24; k++) begin
        m = (m * m) >> 30;
        frac <<= 1;
        if (m >= (64'd1 << 31)) begin
          frac |= 1; m >>= 1;
        end
      end
      lg = (longint'(30 - p) << 24) - frac;
      e = (lg * n) >> 8;
      ip = e >> 24;
      if (ip >= 31) return 0;
      f = e & 64'hFF_FFFF;
      res = Q30_ONE;
      c = int_sqrt(64'd1 << 59);
      for (int k = 1; k <= 24; k++) begin
        if (f[24-k]) res = (res * c) >> 30;
        c = int_sqrt(c << 30);
      end
      return res >> ip;
    endfunction

    static function logic [23:0] to_q8_16(longint unsigned v);
      v >>= (32 - RESULT_FRAC_BITS);
      return v > 64'hFF_FFFF ? 24'hFF_FFFF : v[23:0];
    endfunction

    function brdf_res_t shade(logic [IN_W-1:0] item);
      longint nv[3], wo[3], wi[3], rf[3], ct, dwn, dt;
      longint unsigned mg[3], ks, kd, n, t, d32, ca, a, spec, len2, nrm, mx;
      int s;
      brdf_res_t r;
      for (int i = 0; i < 3; i++) begin
        nv[i] = longint'($signed(item[16*i +: 16]));
        wo[i] = longint'($signed(item[16*(3+i) +: 16]));
        wi[i] = longint'($signed(item[16*(6+i) +: 16]));
      end
      ct = wi[0]*nv[0] + wi[1]*nv[1] + wi[2]*nv[2];
      if (ct <= 0) return '0;
      ks = ks_reg > 17'd65536 ? 65536 : ks_reg;
      kd = 65536 - ks;
      n = shin < 16'd256 ? 256 : shin;
      t = (kd * longint'(ct)) >> 16;
      d32 = (t * INV_PI) >> (2 * VECTOR_FRAC_BITS);
      dwn = wo[0]*nv[0] + wo[1]*nv[1] + wo[2]*nv[2];
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        rf[i] = 2*dwn*nv[i] - wo[i] * (64'sd1 <<< (2*VECTOR_FRAC_BITS));
        mg[i] = rf[i] < 0 ? -rf[i] : rf[i];
        if (mg[i] > mx) mx = mg[i];
      end
      s = 0;
      while ((mx >> s) >= Q30_ONE) s++;
      len2 = 0;
      for (int i = 0; i < 3; i++) begin
        mg[i] >>= s;
        rf[i] = rf[i] < 0 ? -longint'(mg[i]) : longint'(mg[i]);
        len2 += mg[i] * mg[i];
      end
      nrm = int_sqrt(len2);
      dt = wi[0]*rf[0] + wi[1]*rf[1] + wi[2]*rf[2];
      if (nrm == 0 || dt <= 0) ca = 0;
      else if (longint'(dt) >= nrm) ca = Q30_ONE;
      else ca = (longint'(dt) << 30) / nrm;
      a = (ks * (n + 256) * INV_PI) >> 33;
      spec = ((a * cos_pow(ca, n)) >> 30) << 8;
      r.red     = to_q8_16(((alb_r * d32) >> 16) + spec);
      r.green   = to_q8_16(((alb_g * d32) >> 16) + spec);
      r.blue    = to_q8_16(((alb_b * d32) >> 16) + spec);
      r.density = to_q8_16(d32 + spec);
      return r;
    endfunction

    function void note_item(logic [IN_W-1:0] item);
      pending.push_back(shade(item));
    endfunction

    function void check_result(logic [OUT_W-1:0] data);
      brdf_res_t got, exp_r;
      got = data;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", data);
        return;
      end
      exp_r = pending.pop_front();
      if (got != exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp r=%h g=%h b=%h pdf=%h got r=%h g=%h b=%h pdf=%h",
                   exp_r.red, exp_r.green, exp_r.blue, exp_r.density,
                   got.red, got.green, got.blue, got.density);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [16:0]        cfg_data = '0;

  brdf_scoreboard sb = new();

  int  send_idle_pct = 0;   // sender gap chance, percent
  int  recv_idle_pct = 0;   // receiver stall chance, percent
  int  hold_cycles   = 0;   // long receiver hold-off request

  always #1 clk = ~clk;

  phong_brdf_eval dut (.*);

  // receiver: random stalls, plus a long counted hold-off on request
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one item; gaps come before valid is raised so valid stays high back to back
  task automatic send_item(logic [IN_W-1:0] item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= item;
    do @(posedge clk); while (!in_tready);
    sb.note_item(item);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
  endtask

  // valid drops for one cycle after each write
  task automatic write_reg(cfg_idx_t idx, logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // every expected result in, then latency margin so the pipeline is empty
  task automatic drain();
    stop_sending();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // random unit-ish vector, Q1.14; occasionally raw extremes
  function automatic logic [47:0] rand_vec();
    int x, y, z;
    real len;
    if ($urandom_range(9) == 0)
      return {16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384),
              16'($urandom_range(32768) - 16384)};
    if ($urandom_range(19) == 0) return {$urandom(), 16'($urandom())};
    do begin
      x = $urandom_range(2000) - 1000;
      y = $urandom_range(2000) - 1000;
      z = $urandom_range(2000) - 1000;
      len = $sqrt(real'(x*x + y*y + z*z));
    end while (len < 100.0 || len > 1000.0);
    return {16'($rtoi(z * 16384.0 / len)), 16'($rtoi(y * 16384.0 / len)),
            16'($rtoi(x * 16384.0 / len))};
  endfunction

  // mostly lit items: flip the light into the normal's hemisphere
  function automatic logic [IN_W-1:0] rand_item();
    logic [47:0] nrm, wo, wi;
    longint dt;
    nrm = rand_vec(); wo = rand_vec(); wi = rand_vec();
    dt = 0;
    for (int i = 0; i < 3; i++)
      dt += longint'($signed(nrm[16*i +: 16])) * longint'($signed(wi[16*i +: 16]));
    if (dt < 0 && $urandom_range(9) < 8)
      for (int i = 0; i < 3; i++) wi[16*i +: 16] = -$signed(wi[16*i +: 16]);
    // sometimes make the light sit on the mirror direction (cosAlpha near one)
    if ($urandom_range(9) == 0) begin
      longint d2;
      d2 = 0;
      for (int i = 0; i < 3; i++)
        d2 += longint'($signed(wo[16*i +: 16])) * longint'($signed(nrm[16*i +: 16]));
      for (int i = 0; i < 3; i++)
        wi[16*i +: 16] = 16'((2*d2*longint'($signed(nrm[16*i +: 16])) >>> 28)
                         - longint'($signed(wo[16*i +: 16])));
    end
    return {wi, wo, nrm};
  endfunction

  function automatic logic [IN_W-1:0] pack_item(int nx, int ny, int nz, int ox, int oy,
                                                int oz, int ix, int iy, int iz);
    return {16'(iz), 16'(iy), 16'(ix), 16'(oz), 16'(oy), 16'(ox),
            16'(nz), 16'(ny), 16'(nx)};
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_item(rand_item());
  endtask

  task automatic random_config();
    write_reg(CFG_ALBEDO_RED,   17'($urandom_range(65535)));
    write_reg(CFG_ALBEDO_GREEN, 17'($urandom_range(65535)));
    write_reg(CFG_ALBEDO_BLUE,  17'($urandom_range(65535)));
    write_reg(CFG_SPEC_WEIGHT,  17'($urandom_range(131071)));
    write_reg(CFG_SHININESS,    17'($urandom_range(65535)));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings
    send_item(pack_item(0, 0, 16384, 0, 0, 16384, 0, 0, 16384));      // all on normal
    send_item(pack_item(0, 0, 16384, 0, 0, 16384, 0, 0, -16384));     // light below
    send_item(pack_item(0, 0, 16384, 0, 0, 16384, 16384, 0, 0));      // grazing, ct zero
    send_item(pack_item(0, 0, 16384, 11585, 0, 11585, -11585, 0, 11585)); // mirror
    send_item(pack_item(0, 0, 16384, 11585, 0, 11585, 11585, 0, 11585));  // cosAlpha 0
    send_item(pack_item(0, 0, 0, 0, 0, 0, 0, 0, 0));                  // all zero
    send_item(pack_item(0, 0, 16384, 0, 0, 0, 0, 0, 16384));          // degenerate r
    send_item(pack_item(-32768, -32768, -32768, 32767, 32767, 32767,
                        -32768, -32768, -32768));                     // non-unit, saturate
    send_item(pack_item(32767, 32767, 32767, -32768, 32767, -32768,
                        32767, 32767, 32767));
    send_item(pack_item(16384, 0, 0, 9000, 9000, 9000, 16000, 2000, 1000));
    drain();

    // extremes of the registers
    write_reg(CFG_ALBEDO_RED, 17'd65535);
    write_reg(CFG_ALBEDO_GREEN, 17'd0);
    write_reg(CFG_ALBEDO_BLUE, 17'd1);
    write_reg(CFG_SPEC_WEIGHT, 17'd131071);   // clamps to one
    write_reg(CFG_SHININESS, 17'd0);          // clamps to 1.0
    for (int i = 0; i < 5; i++) send_item(rand_item());
    send_item(pack_item(0, 0, 16384, 0, 0, 16384, 0, 0, 16384));
    drain();
    write_reg(CFG_SPEC_WEIGHT, 17'd0);
    write_reg(CFG_SHININESS, 17'd65535);
    for (int i = 0; i < 5; i++) send_item(rand_item());
    send_item(pack_item(0, 0, 16384, 11585, 0, 11585, -11000, 0, 12000));
    drain();
    write_reg(CFG_SPEC_WEIGHT, 17'd65536);
    write_reg(CFG_SHININESS, 17'd256);
    for (int i = 0; i < 4; i++) send_item(rand_item());
    drain();

    // random, sender idles more rarely than the receiver
    send_idle_pct = 27; recv_idle_pct = 74;
    random_config();
    random_phase(400);
    // long receiver hold-off while items keep coming: queue fills, input stalls
    hold_cycles = 400;
    random_phase(150);
    drain();   // sender pauses until every result is in
    send_idle_pct = 74; recv_idle_pct = 27;
    random_config();
    random_phase(450);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_config();
    random_phase(350);
    drain();
    write_reg(CFG_ALBEDO_RED, 17'd52429);
    write_reg(CFG_SHININESS, 17'd8192);
    random_phase(300);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
sv/pbe_pkg.sv
sv/pbe_front.sv
sv/pbe_queue.sv
sv/pbe_cosine.sv
sv/pbe_power.sv
sv/phong_brdf_eval.sv
dv/tb_phong_brdf_eval.sv
